### rtl/vvfm_pkg.sv
// shared constants, types and helpers of the voxel visible face mask unit
package vvfm_pkg;

	localparam int GRID_DIM    = 32;
	localparam int MAX_THROUGH = 4;
	localparam int ID_BITS     = 8;
	localparam int ID_FIELDS   = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam int FACES       = 6;
	localparam int THROUGH_LIM = (MAX_THROUGH < ID_FIELDS) ? MAX_THROUGH : ID_FIELDS;
	localparam int CW          = $clog2(GRID_DIM);
	localparam int AW          = 3 * CW;
	localparam int CELLS       = GRID_DIM * GRID_DIM * GRID_DIM;
	localparam int EW          = (CW + 1 > 6) ? CW + 1 : 6;

	// face order +x,-x,+y,-y,+z,-z
	localparam logic [2:0] FACE_PX   = 3'd0;
	localparam logic [2:0] FACE_NX   = 3'd1;
	localparam logic [2:0] FACE_PY   = 3'd2;
	localparam logic [2:0] FACE_NY   = 3'd3;
	localparam logic [2:0] FACE_PZ   = 3'd4;
	localparam logic [2:0] FACE_NZ   = 3'd5;
	localparam logic [2:0] FACE_LAST = FACE_NZ;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] REG_SIZE_X = 2'd0;
	localparam logic [1:0] REG_SIZE_Y = 2'd1;
	localparam logic [1:0] REG_SIZE_Z = 2'd2;

	typedef logic [ID_BITS-1:0] id_t;
	typedef logic [AW-1:0]      addr_t;
	typedef logic [EW-1:0]      ext_t;

	typedef struct packed {
		ext_t x;
		ext_t y;
		ext_t z;
	} ext_cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	typedef struct packed {
		logic                        query;
		logic                        wr_ok;
		addr_t                       wr_addr;
		id_t                         wr_id;
		logic [FACES-1:0]            nb_in;
		addr_t [FACES-1:0]           nb_addr;
		id_t [ID_FIELDS-1:0]         ids;
		logic [ID_FIELDS-1:0]        id_en;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_DONE
	} back_state_t;

	function automatic addr_t cell_addr(ext_t x, ext_t y, ext_t z);
		return {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
	endfunction

	function automatic id_t to_id(logic [7:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[ID_BITS-1:0];
	endfunction

endpackage

### rtl/vvfm_front.sv
// front end: input handshake, bounds checks and neighbour addresses per item
module vvfm_front import vvfm_pkg::*; (
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         opcode,
	input  logic [4:0]   pos_x,
	input  logic [4:0]   pos_y,
	input  logic [4:0]   pos_z,
	input  logic [7:0]   write_id,
	input  logic [2:0]   through_count,
	input  logic [7:0]   through_id_0,
	input  logic [7:0]   through_id_1,
	input  logic [7:0]   through_id_2,
	input  logic [7:0]   through_id_3,
	input  ext_cfg_t     ext,
	input  fifo_status_t q_stat,
	input  logic         clearing,
	output logic         push,
	output cmd_t         cmd
);

	ext_t x, y, z, xp, xm, yp, ym, zp, zm;
	logic in_x, in_y, in_z, up_x, up_y, up_z, dn_x, dn_y, dn_z;
	logic [7:0] tid [ID_FIELDS];
	logic [2:0] cnt;

	assign in_ready = !clearing && !q_stat.full;
	assign push     = in_valid && in_ready;

	always_comb begin
		x  = ext_t'(pos_x);
		y  = ext_t'(pos_y);
		z  = ext_t'(pos_z);
		xp = x + ext_t'(1);
		yp = y + ext_t'(1);
		zp = z + ext_t'(1);
		xm = x - ext_t'(1);
		ym = y - ext_t'(1);
		zm = z - ext_t'(1);

		in_x = x < ext.x;
		in_y = y < ext.y;
		in_z = z < ext.z;
		up_x = xp < ext.x;
		up_y = yp < ext.y;
		up_z = zp < ext.z;
		// below zero is outside
		dn_x = (x != '0) && (xm < ext.x);
		dn_y = (y != '0) && (ym < ext.y);
		dn_z = (z != '0) && (zm < ext.z);

		tid[0] = through_id_0;
		tid[1] = through_id_1;
		tid[2] = through_id_2;
		tid[3] = through_id_3;
		cnt = (through_count > 3'(THROUGH_LIM)) ? 3'(THROUGH_LIM) : through_count;

		cmd.query   = (opcode == OP_QUERY);
		cmd.wr_ok   = (x < ext_t'(GRID_DIM)) && (y < ext_t'(GRID_DIM)) && (z < ext_t'(GRID_DIM));
		cmd.wr_addr = cell_addr(x, y, z);
		cmd.wr_id   = to_id(write_id);

		cmd.nb_in[FACE_PX] = up_x && in_y && in_z;
		cmd.nb_in[FACE_NX] = dn_x && in_y && in_z;
		cmd.nb_in[FACE_PY] = in_x && up_y && in_z;
		cmd.nb_in[FACE_NY] = in_x && dn_y && in_z;
		cmd.nb_in[FACE_PZ] = in_x && in_y && up_z;
		cmd.nb_in[FACE_NZ] = in_x && in_y && dn_z;

		// wrapped addresses of hidden faces are still read, but nb_in masks their data
		cmd.nb_addr[FACE_PX] = cell_addr(xp, y, z);
		cmd.nb_addr[FACE_NX] = cell_addr(xm, y, z);
		cmd.nb_addr[FACE_PY] = cell_addr(x, yp, z);
		cmd.nb_addr[FACE_NY] = cell_addr(x, ym, z);
		cmd.nb_addr[FACE_PZ] = cell_addr(x, y, zp);
		cmd.nb_addr[FACE_NZ] = cell_addr(x, y, zm);

		for (int k = 0; k < ID_FIELDS; k++) begin
			cmd.ids[k]   = to_id(tid[k]);
			cmd.id_en[k] = (k < int'(cnt));
		end
	end

endmodule

### rtl/vvfm_fifo.sv
// command queue between front and back end
module vvfm_fifo import vvfm_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  cmd_t         din,
	input  logic         pop,
	output cmd_t         head,
	output fifo_status_t stat
);

	localparam int PW   = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	cmd_t            slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] cnt_q;

	assign head       = slot_q[rd_ptr_q];
	assign stat.full  = (cnt_q == CNTW'(DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + CNTW'(1);
				2'b01: cnt_q <= cnt_q - CNTW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/vvfm_back.sv
// back end: voxel store, clearing pass, face read sequence and result register
module vvfm_back import vvfm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         head,
	input  fifo_status_t q_stat,
	output logic         pop,
	output logic         clearing,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [5:0]   face_mask,
	output logic [2:0]   face_total
);

	back_state_t state_q, state_d;
	addr_t       clr_q;
	logic [2:0]  face_q;
	cmd_t        cmd_q;

	id_t         mem [CELLS];
	logic        mem_we, mem_re;
	addr_t       mem_waddr, mem_raddr;
	id_t         mem_wdata;

	logic        iss_vld, iss_in;
	logic [2:0]  iss_face;
	logic        chk_vld_s1, chk_in_s1;
	logic [2:0]  chk_face_s1;
	id_t         rd_data_s1;

	logic [5:0]  mask_q, mask_all, new_bit;
	logic [2:0]  total;
	logic        match, hit, start, load_res;
	logic        res_vld_q;
	logic [5:0]  res_mask_q;
	logic [2:0]  res_total_q;

	assign out_valid  = res_vld_q;
	assign face_mask  = res_mask_q;
	assign face_total = res_total_q;

	// check of the neighbour read registered in rd_data_s1
	always_comb begin
		match = 1'b0;
		for (int k = 0; k < ID_FIELDS; k++) begin
			match = match || (cmd_q.id_en[k] && (cmd_q.ids[k] == rd_data_s1));
		end
		hit      = chk_in_s1 && ((rd_data_s1 == '0) || match);
		new_bit  = (chk_vld_s1 && hit) ? (6'b1 << chk_face_s1) : 6'b0;
		mask_all = mask_q | new_bit;
		total    = '0;
		for (int i = 0; i < FACES; i++) begin
			total = total + 3'(mask_all[i]);
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		clearing  = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		mem_raddr = cmd_q.nb_addr[face_q];
		iss_vld   = 1'b0;
		iss_face  = face_q;
		iss_in    = cmd_q.nb_in[face_q];
		start     = 1'b0;
		load_res  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				clearing = 1'b1;
				mem_we   = 1'b1;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!q_stat.empty) begin
					pop = 1'b1;
					if (head.query) begin
						mem_re    = 1'b1;
						mem_raddr = head.nb_addr[FACE_PX];
						iss_vld   = 1'b1;
						iss_face  = FACE_PX;
						iss_in    = head.nb_in[FACE_PX];
						start     = 1'b1;
						state_d   = ST_READ;
					end else begin
						mem_we    = head.wr_ok;
						mem_waddr = head.wr_addr;
						mem_wdata = head.wr_id;
					end
				end
			end
			ST_READ: begin
				mem_re  = 1'b1;
				iss_vld = 1'b1;
				if (face_q == FACE_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!res_vld_q || out_ready) begin
					load_res = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_s1 <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q <= head;
		end
		chk_face_s1 <= iss_face;
		chk_in_s1   <= iss_in;
		if (load_res) begin
			res_mask_q  <= mask_all;
			res_total_q <= total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			face_q     <= '0;
			chk_vld_s1 <= 1'b0;
			mask_q     <= '0;
			res_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			chk_vld_s1 <= iss_vld;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + addr_t'(1);
			end
			if (start) begin
				face_q <= FACE_NX;
				mask_q <= '0;
			end else begin
				if (state_q == ST_READ) begin
					face_q <= face_q + 3'd1;
				end
				mask_q <= mask_all;
			end
			if (load_res) begin
				res_vld_q <= 1'b1;
			end else if (out_ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/voxel_visible_face_mask_unit.sv
// top level of the voxel visible face mask unit
// Keeps a 32x32x32 grid of 8-bit voxel ids (0 = empty) and answers face visibility
// queries. After reset the store is swept to zero, one cell per cycle; in_ready stays
// low during that pass, size registers can still be written.
// A write item is done in the idle state of the back end and gives no transfer on the output.
// A query item issues its six neighbour reads one per cycle through the read port
// of the voxel store, then the done state checks the last read and loads the
// result register once the previous result is taken or absent. Items are classified and bounds-checked
// on entry and wait in a two-entry queue, so the input keeps taking items while the
// back end works and while a result waits for out_ready, until two items are waiting;
// then in_ready drops until the back end takes one. A face is visible when its
// neighbour lies inside the size registers (clipped to the grid) and is empty or
// matches one of the first through_count see-through ids.
module voxel_visible_face_mask_unit import vvfm_pkg::*; #(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration write port
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data,
	// input item channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       opcode,
	input  logic [4:0] pos_x,
	input  logic [4:0] pos_y,
	input  logic [4:0] pos_z,
	input  logic [7:0] write_id,
	input  logic [2:0] through_count,
	input  logic [7:0] through_id_0,
	input  logic [7:0] through_id_1,
	input  logic [7:0] through_id_2,
	input  logic [7:0] through_id_3,
	// result channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic [5:0] face_mask,
	output logic [2:0] face_total
);

	logic [5:0]   size_x_q, size_y_q, size_z_q;
	ext_cfg_t     ext;
	fifo_status_t q_stat;
	cmd_t         cmd, head;
	logic         push, pop, clearing;

	// size registers, reset to the full grid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= 6'd32;
			size_y_q <= 6'd32;
			size_z_q <= 6'd32;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SIZE_X: size_x_q <= cfg_data;
				REG_SIZE_Y: size_y_q <= cfg_data;
				REG_SIZE_Z: size_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// extents above the grid act as the grid size
	always_comb begin
		ext.x = (ext_t'(size_x_q) > ext_t'(GRID_DIM)) ? ext_t'(GRID_DIM) : ext_t'(size_x_q);
		ext.y = (ext_t'(size_y_q) > ext_t'(GRID_DIM)) ? ext_t'(GRID_DIM) : ext_t'(size_y_q);
		ext.z = (ext_t'(size_z_q) > ext_t'(GRID_DIM)) ? ext_t'(GRID_DIM) : ext_t'(size_z_q);
	end

	// classify and bounds-check on entry
	vvfm_front u_front (
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.write_id      (write_id),
		.through_count (through_count),
		.through_id_0  (through_id_0),
		.through_id_1  (through_id_1),
		.through_id_2  (through_id_2),
		.through_id_3  (through_id_3),
		.ext           (ext),
		.q_stat        (q_stat),
		.clearing      (clearing),
		.push          (push),
		.cmd           (cmd)
	);

	// decouples input transfers from store access
	vvfm_fifo #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd),
		.pop    (pop),
		.head   (head),
		.stat   (q_stat)
	);

	// store, neighbour reads and output register
	vvfm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_stat     (q_stat),
		.pop        (pop),
		.clearing   (clearing),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.face_mask  (face_mask),
		.face_total (face_total)
	);

endmodule

### rtl/vvfm_checker.sv
// port-level checks of the voxel visible face mask unit and their binding
module vvfm_checker import vvfm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       opcode,
	input logic       out_valid,
	input logic       out_ready,
	input logic [5:0] face_mask,
	input logic [2:0] face_total
);

	logic [15:0] pend_q;
	logic        q_acc, r_acc;

	assign q_acc = in_valid && in_ready && (opcode == OP_QUERY);
	assign r_acc = out_valid && out_ready;

	// queries accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 16'(q_acc) - 16'(r_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(face_mask) && $stable(face_total))
		else $error("result changed while stalled");

	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> face_total == 3'($countones(face_mask)))
		else $error("face total does not match mask");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != '0)
		else $error("result without pending query");

endmodule

bind voxel_visible_face_mask_unit vvfm_checker u_vvfm_checker (.*);

### test/voxel_face_check_pkg.sv
// item types and the face visibility tracker used by the voxel face mask testbench
`timescale 1ns / 100ps

package voxel_face_check_pkg;
	import vvfm_pkg::*;

	typedef struct packed {
		logic                opcode;
		logic [4:0]          x;
		logic [4:0]          y;
		logic [4:0]          z;
		id_t                 wid;
		logic [2:0]          cnt;
		id_t [ID_FIELDS-1:0] thru;
	} voxel_item_t;

	typedef struct packed {
		logic [5:0] mask;
		logic [2:0] total;
	} face_answer_t;

	class face_mask_tracker;
		id_t          voxel_copy [CELLS];
		logic [5:0]   span_x;
		logic [5:0]   span_y;
		logic [5:0]   span_z;
		face_answer_t answers_due [$];
		int           faults;

		function new();
			foreach (voxel_copy[i])
				voxel_copy[i] = '0;
			span_x = 6'd32;
			span_y = 6'd32;
			span_z = 6'd32;
			faults = 0;
		endfunction

		function int slot(int x, int y, int z);
			return x + GRID_DIM * (y + GRID_DIM * z);
		endfunction

		function void take_size(logic [1:0] idx, logic [5:0] val);
			case (idx)
				REG_SIZE_X: span_x = val;
				REG_SIZE_Y: span_y = val;
				REG_SIZE_Z: span_z = val;
				default: ;
			endcase
		endfunction

		// a write updates the copy of the grid, a query adds one expected answer
		function void take_item(voxel_item_t it);
			int           ex;
			int           ey;
			int           ez;
			int           nx;
			int           ny;
			int           nz;
			int           lim;
			id_t          v;
			logic         seen;
			face_answer_t want;

			if (it.opcode == OP_WRITE) begin
				voxel_copy[slot(it.x, it.y, it.z)] = it.wid;
				return;
			end
			ex = (span_x > GRID_DIM) ? GRID_DIM : span_x;
			ey = (span_y > GRID_DIM) ? GRID_DIM : span_y;
			ez = (span_z > GRID_DIM) ? GRID_DIM : span_z;
			lim = (it.cnt > THROUGH_LIM) ? THROUGH_LIM : it.cnt;
			want = '0;
			for (int f = 0; f < FACES; f++) begin
				nx = it.x;
				ny = it.y;
				nz = it.z;
				case (3'(f))
					FACE_PX: nx = nx + 1;
					FACE_NX: nx = nx - 1;
					FACE_PY: ny = ny + 1;
					FACE_NY: ny = ny - 1;
					FACE_PZ: nz = nz + 1;
					default: nz = nz - 1;
				endcase
				if (nx < 0 || ny < 0 || nz < 0 || nx >= ex || ny >= ey || nz >= ez)
					continue;
				v = voxel_copy[slot(nx, ny, nz)];
				seen = (v == '0);
				for (int k = 0; k < lim; k++)
					if (v == it.thru[k])
						seen = 1'b1;
				if (seen) begin
					want.mask[f] = 1'b1;
					want.total = want.total + 3'd1;
				end
			end
			answers_due = {answers_due, want};
		endfunction

		function void match_answer(logic [5:0] mask, logic [2:0] total);
			face_answer_t want;

			if (answers_due.size() == 0) begin
				$error("face result with nothing pending: face_mask=%0d face_total=%0d",
					mask, total);
				faults++;
				return;
			end
			want = answers_due.pop_front();
			if (mask !== want.mask) begin
				$error("face_mask expected %0d actual %0d", want.mask, mask);
				faults++;
			end
			if (total !== want.total) begin
				$error("face_total expected %0d actual %0d", want.total, total);
				faults++;
			end
		endfunction

		function int outstanding();
			return answers_due.size();
		endfunction
	endclass

endpackage

### test/testbench.sv
// testbench for the voxel visible face mask unit: directed and random items checked per result
`timescale 1ns / 100ps

module testbench;
	import vvfm_pkg::*;
	import voxel_face_check_pkg::*;

	localparam int PHASES     = 8;
	localparam int PHASE_ITEMS = 56;
	localparam int HOLD_PHASE = 2;
	localparam int HOLD_CYCLES = 300;

	// size settings per phase, a negative entry means pick at random
	localparam int PLAN_X [PHASES] = '{1, 0, 63, 4, 33, 2, -1, -1};
	localparam int PLAN_Y [PHASES] = '{1, 4, 63, 3, 2, 32, -1, -1};
	localparam int PLAN_Z [PHASES] = '{1, 4, 63, 2, 0, 5, -1, -1};

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [5:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic       opcode;
	logic [4:0] pos_x;
	logic [4:0] pos_y;
	logic [4:0] pos_z;
	logic [7:0] write_id;
	logic [2:0] through_count;
	logic [7:0] through_id_0;
	logic [7:0] through_id_1;
	logic [7:0] through_id_2;
	logic [7:0] through_id_3;
	logic       out_valid;
	logic       out_ready;
	logic [5:0] face_mask;
	logic [2:0] face_total;

	face_mask_tracker book;
	// set by the stimulus side to ask the receiver for one long hold-off
	logic             hold_ask;

	voxel_visible_face_mask_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.write_id     (write_id),
		.through_count(through_count),
		.through_id_0 (through_id_0),
		.through_id_1 (through_id_1),
		.through_id_2 (through_id_2),
		.through_id_3 (through_id_3),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.face_mask    (face_mask),
		.face_total   (face_total)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog: covers the clearing sweep plus every item at its slowest
	initial begin
		#4_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	// monitor: everything is sampled at the rising edge, before the block updates
	always @(posedge clk) begin : watch
		voxel_item_t seen;
		if (arst_n) begin
			if (cfg_we)
				book.take_size(cfg_index, cfg_data);
			if (in_valid && in_ready) begin
				seen.opcode = opcode;
				seen.x = pos_x;
				seen.y = pos_y;
				seen.z = pos_z;
				seen.wid = write_id;
				seen.cnt = through_count;
				seen.thru[0] = through_id_0;
				seen.thru[1] = through_id_1;
				seen.thru[2] = through_id_2;
				seen.thru[3] = through_id_3;
				book.take_item(seen);
			end
			if (out_valid && out_ready)
				book.match_answer(face_mask, face_total);
		end
	end

	// receiver: stretches of always-ready, random, stalled or toggling out_ready,
	// plus one long hold-off on request so the input side backs up
	initial begin : receiver
		int   mode;
		int   span;
		logic held;
		out_ready = 1'b0;
		held = 1'b0;
		forever begin
			if (hold_ask && !held) begin
				held = 1'b1;
				@(negedge clk) out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(1, 40);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= 1'b0;
					default: out_ready <= ~out_ready;
				endcase
			end
		end
	end

	// ids cluster on a few small values so see-through matches actually happen
	function automatic id_t pick_id();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			return '0;
		if (roll < 85)
			return id_t'($urandom_range(1, 6));
		return id_t'($urandom_range(0, 255));
	endfunction

	function automatic voxel_item_t mk(logic op, int x, int y, int z, int wid, int cnt,
			int i0, int i1, int i2, int i3);
		voxel_item_t it;
		it.opcode = op;
		it.x = 5'(x);
		it.y = 5'(y);
		it.z = 5'(z);
		it.wid = id_t'(wid);
		it.cnt = 3'(cnt);
		it.thru[0] = id_t'(i0);
		it.thru[1] = id_t'(i1);
		it.thru[2] = id_t'(i2);
		it.thru[3] = id_t'(i3);
		return it;
	endfunction

	// items mostly land in the low or high corner so writes and queries meet
	function automatic voxel_item_t rand_item();
		voxel_item_t it;
		int          zone;
		int          base;
		zone = $urandom_range(0, 99);
		base = (zone < 60) ? 0 : (zone < 85) ? 28 : -1;
		it.opcode = ($urandom_range(0, 99) < 55) ? OP_QUERY : OP_WRITE;
		it.x = (base < 0) ? 5'($urandom_range(0, 31)) : 5'(base + $urandom_range(0, 3));
		it.y = (base < 0) ? 5'($urandom_range(0, 31)) : 5'(base + $urandom_range(0, 3));
		it.z = (base < 0) ? 5'($urandom_range(0, 31)) : 5'(base + $urandom_range(0, 3));
		it.wid = pick_id();
		it.cnt = 3'($urandom_range(0, 7));
		for (int k = 0; k < ID_FIELDS; k++)
			it.thru[k] = pick_id();
		return it;
	endfunction

	// offer one item and hold it until the transfer happens
	task automatic push_item(voxel_item_t it);
		@(negedge clk);
		in_valid <= 1'b1;
		opcode <= it.opcode;
		pos_x <= it.x;
		pos_y <= it.y;
		pos_z <= it.z;
		write_id <= it.wid;
		through_count <= it.cnt;
		through_id_0 <= it.thru[0];
		through_id_1 <= it.thru[1];
		through_id_2 <= it.thru[2];
		through_id_3 <= it.thru[3];
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic idle_input(int cycles);
		@(negedge clk) in_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 6'(val);
	endtask

	task automatic write_sizes(int sx, int sy, int sz);
		write_reg(REG_SIZE_X, sx);
		write_reg(REG_SIZE_Y, sy);
		write_reg(REG_SIZE_Z, sz);
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	// sender: bursts of random length, random gaps, sometimes none
	task automatic feed_items(int count);
		int sent;
		int burst;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst && sent < count; b++) begin
				push_item(rand_item());
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				idle_input($urandom_range(1, 15));
		end
	endtask

	// wait for every expected result, then let any trailing writes clear the back end
	task automatic settle();
		idle_input(1);
		while (book.outstanding() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	initial begin : stimulus
		int sx;
		int sy;
		int sz;

		book = new();
		hold_ask = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SIZE_X;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = OP_WRITE;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		write_id = '0;
		through_count = '0;
		through_id_0 = '0;
		through_id_1 = '0;
		through_id_2 = '0;
		through_id_3 = '0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed part at the reset sizes; the first transfer waits out the clearing sweep
		// empty grid at three corners: only the inward faces show
		push_item(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		push_item(mk(OP_QUERY, 31, 31, 31, 255, 0, 0, 0, 0, 0));
		push_item(mk(OP_QUERY, 31, 0, 31, 0, 0, 0, 0, 0, 0));
		// fill the three upper neighbors of the origin
		push_item(mk(OP_WRITE, 1, 0, 0, 7, 0, 0, 0, 0, 0));
		push_item(mk(OP_WRITE, 0, 1, 0, 255, 0, 0, 0, 0, 0));
		push_item(mk(OP_WRITE, 0, 0, 1, 128, 0, 0, 0, 0, 0));
		// no see-through ids in use: everything hidden; matching ids in use show their faces
		push_item(mk(OP_QUERY, 0, 0, 0, 0, 0, 7, 255, 128, 0));
		push_item(mk(OP_QUERY, 0, 0, 0, 0, 1, 7, 255, 128, 0));
		push_item(mk(OP_QUERY, 0, 0, 0, 0, 4, 0, 7, 255, 128));
		// count above four saturates, so the last id still counts
		push_item(mk(OP_QUERY, 0, 0, 0, 0, 7, 1, 2, 3, 128));
		push_item(mk(OP_QUERY, 0, 0, 0, 0, 5, 9, 9, 9, 255));
		push_item(mk(OP_QUERY, 0, 0, 0, 0, 3, 1, 2, 3, 128));
		// see-through id of zero changes nothing
		push_item(mk(OP_QUERY, 0, 0, 0, 0, 4, 0, 0, 0, 0));
		// querying an empty voxel and a filled one
		push_item(mk(OP_QUERY, 1, 1, 1, 0, 0, 0, 0, 0, 0));
		push_item(mk(OP_QUERY, 1, 0, 0, 0, 2, 255, 128, 0, 0));
		// far corner with two filled neighbors
		push_item(mk(OP_WRITE, 31, 31, 30, 8'h55, 0, 0, 0, 0, 0));
		push_item(mk(OP_WRITE, 30, 31, 31, 8'hAA, 0, 0, 0, 0, 0));
		push_item(mk(OP_QUERY, 31, 31, 31, 0, 2, 8'hAA, 8'h55, 0, 0));
		push_item(mk(OP_QUERY, 31, 31, 31, 0, 1, 8'hAA, 8'h55, 0, 0));
		// clearing a voxel makes its face visible again
		push_item(mk(OP_WRITE, 1, 0, 0, 0, 0, 0, 0, 0, 0));
		push_item(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		settle();

		// random phases, each under its own size setting
		for (int p = 0; p < PHASES; p++) begin
			sx = (PLAN_X[p] < 0) ? ($urandom_range(0, 1) ? $urandom_range(0, 6) :
				$urandom_range(0, 63)) : PLAN_X[p];
			sy = (PLAN_Y[p] < 0) ? ($urandom_range(0, 1) ? $urandom_range(0, 6) :
				$urandom_range(0, 63)) : PLAN_Y[p];
			sz = (PLAN_Z[p] < 0) ? ($urandom_range(0, 1) ? $urandom_range(0, 6) :
				$urandom_range(0, 63)) : PLAN_Z[p];
			write_sizes(sx, sy, sz);
			if (p == HOLD_PHASE)
				hold_ask = 1'b1;
			feed_items(PHASE_ITEMS);
			settle();
		end

		if (book.faults == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

### voxel_visible_face_mask_unit.f
rtl/vvfm_pkg.sv
rtl/vvfm_front.sv
rtl/vvfm_fifo.sv
rtl/vvfm_back.sv
rtl/voxel_visible_face_mask_unit.sv
rtl/vvfm_checker.sv
test/voxel_face_check_pkg.sv
test/testbench.sv
